// File: rtl/dem_delta_record_decoder_macros.svh
// ----------------------------------------------------------------------------
// dem delta record decoder assertion macros
// concurrent assertion shorthands, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef DEM_DELTA_RECORD_DECODER_MACROS_SVH
`define DEM_DELTA_RECORD_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define DDR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define DDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define DDR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DDR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/ddr_pkg.sv
// ----------------------------------------------------------------------------
// ddr_pkg
// types, constants and the code-to-delta function of the delta record decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ddr_pkg;

    localparam logic [31:0] OUT_OF_RANGE = 32'h8000_0000;
    localparam logic [8:0]  LONG_COUNT_BASE = 9'd32;

    // record type from header bits 7..5
    typedef enum logic [2:0] {
        RT_MISSING = 3'd0,
        RT_ZERO    = 3'd1,
        RT_D4      = 3'd2,
        RT_D8      = 3'd3,
        RT_D12     = 3'd4,
        RT_D16     = 3'd5,
        RT_D24     = 3'd6,
        RT_D32     = 3'd7
    } rec_type_t;

    // parser phase, one-hot
    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_COUNT  = 3'b010,
        PH_DATA   = 3'b100
    } phase_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [8:0]         repeat_res;
        logic               truncated;
        logic               end_of_tile;
        logic               last_of_item;
    } result_t;

    typedef struct packed {
        logic        oor;
        logic [31:0] sum;
    } take_t;

    // masks the code to the record width, flags the most negative code,
    // and adds the sign-extended difference to the predictor
    function automatic take_t ddr_take(input logic [31:0] pred, input logic [31:0] code,
                                       input rec_type_t rt);
        take_t       r;
        logic [31:0] d;
        logic        oor;
        case (rt)
            RT_D4:
            begin
                oor = (code[3:0] == 4'h8);
                d   = {{28{code[3]}}, code[3:0]};
            end
            RT_D8:
            begin
                oor = (code[7:0] == 8'h80);
                d   = {{24{code[7]}}, code[7:0]};
            end
            RT_D12:
            begin
                oor = (code[11:0] == 12'h800);
                d   = {{20{code[11]}}, code[11:0]};
            end
            RT_D16:
            begin
                oor = (code[15:0] == 16'h8000);
                d   = {{16{code[15]}}, code[15:0]};
            end
            RT_D24:
            begin
                oor = (code[23:0] == 24'h80_0000);
                d   = {{8{code[23]}}, code[23:0]};
            end
            default:
            begin
                oor = (code == OUT_OF_RANGE);
                d   = code;
            end
        endcase
        r.oor = oor;
        r.sum = pred + d;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ddr_in_if.sv
// ----------------------------------------------------------------------------
// ddr_in_if
// byte channel into the decoder: valid/ready with tile byte and end mark
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ddr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       tile_end;

    modport source (output valid, output in_byte, output tile_end, input ready);
    modport sink (input valid, input in_byte, input tile_end, output ready);
endinterface

`default_nettype wire

// File: rtl/ddr_out_if.sv
// ----------------------------------------------------------------------------
// ddr_out_if
// result channel out of the decoder: valid/ready with one decoded run
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ddr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [8:0]         repeat_res;
    logic               truncated;
    logic               end_of_tile;
    logic               last_of_item;

    modport source (output valid, output value, output repeat_res, output truncated,
                    output end_of_tile, output last_of_item, input ready);
    modport sink (input valid, input value, input repeat_res, input truncated,
                  input end_of_tile, input last_of_item, output ready);
endinterface

`default_nettype wire

// File: rtl/dem_delta_record_decoder.sv
// ----------------------------------------------------------------------------
// dem_delta_record_decoder
// byte-serial decoder of delta-compressed elevation tiles
// ----------------------------------------------------------------------------
// The decoder takes one compressed byte per clock on byte_ch while its result
// buffer has room and produces run items on result_ch: a value and how many
// times it repeats. Header, count and data bytes are all parsed by one pass of
// logic in the accept cycle and the item(s) a byte causes land in a two-entry
// result buffer; with result_ch ready the buffer drains at one item per cycle.
// Most bytes cause zero or one item and then the sustained rate is one byte
// per clock; a 4-bit record byte with two codes causes two items and holds the
// input while the second waits at the buffer's single output port. Items show
// in the cycle after their byte. A tile's last byte (tile_end) resets the
// predictor and parser; unless first in its tile, it sets end_of_tile and, if a
// record is incomplete, truncated on its last item (repeat-0 status item if none).
`timescale 1ns / 1ps
`default_nettype none
`include "dem_delta_record_decoder_macros.svh"

module dem_delta_record_decoder (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ddr_in_if.sink     byte_ch,
    ddr_out_if.source  result_ch
);
    import ddr_pkg::*;

    // decoder state
    logic [31:0] pred_reg,  pred_next;
    phase_t      phase_reg, phase_next;
    rec_type_t   type_reg,  type_next;
    logic [8:0]  rem_reg,   rem_next;
    logic [1:0]  bpos_reg,  bpos_next;
    logic [23:0] part_reg,  part_next;
    logic        first_reg, first_next;

    // result buffer, entry 0 is presented
    result_t     q0_reg, q1_reg;
    logic [1:0]  cnt_reg;

    // per-byte decode
    result_t     res_a, res_b;
    logic [1:0]  res_n;
    logic        byte_acc, out_pop;
    logic [7:0]  b;
    logic        start_go;
    rec_type_t   start_type;
    logic [8:0]  start_cnt;
    logic        take_go, pair_go, split_go;
    logic [31:0] take_code;
    logic [1:0]  last_pos;
    take_t       tk_a, tk_b;

    assign b        = byte_ch.in_byte;
    assign out_pop  = result_ch.valid && result_ch.ready;
    // room for two items once the head item leaves
    assign byte_ch.ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && result_ch.ready);
    assign byte_acc = byte_ch.valid && byte_ch.ready;

    // last byte index of a 16, 24 or 32-bit code
    assign last_pos = 2'(3'(type_reg) - 3'(RT_D12));

    always_comb
    begin
        pred_next  = pred_reg;
        phase_next = phase_reg;
        type_next  = type_reg;
        rem_next   = rem_reg;
        bpos_next  = bpos_reg;
        part_next  = part_reg;
        first_next = first_reg;
        res_n      = 2'd0;
        res_a      = '0;
        res_b      = '0;
        start_go   = 1'b0;
        start_type = type_reg;
        start_cnt  = '0;
        take_go    = 1'b0;
        pair_go    = 1'b0;
        split_go   = 1'b0;
        take_code  = '0;
        tk_a       = '0;
        tk_b       = '0;

        if (byte_acc)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    type_next = rec_type_t'(b[7:5]);
                    if (b[4:0] == 5'd0)
                    begin
                        phase_next = PH_COUNT;
                    end
                    else
                    begin
                        start_go   = 1'b1;
                        start_type = rec_type_t'(b[7:5]);
                        start_cnt  = {4'd0, b[4:0]};
                    end
                end
                PH_COUNT:
                begin
                    start_go  = 1'b1;
                    start_cnt = LONG_COUNT_BASE + {1'b0, b};
                end
                default:
                begin
                    if (type_reg == RT_MISSING || type_reg == RT_ZERO || rem_reg == 9'd0)
                    begin
                        phase_next = PH_HEADER;
                        rem_next   = '0;
                        bpos_next  = '0;
                        part_next  = '0;
                    end
                    else
                    begin
                        case (type_reg)
                            RT_D4:
                            begin
                                take_go   = 1'b1;
                                take_code = {28'd0, b[3:0]};
                                pair_go   = 1'b1;
                            end
                            RT_D8:
                            begin
                                take_go   = 1'b1;
                                take_code = {24'd0, b};
                            end
                            RT_D12:
                            begin
                                case (bpos_reg)
                                    2'd0:
                                    begin
                                        part_next = {16'd0, b};
                                        bpos_next = 2'd1;
                                    end
                                    2'd1:
                                    begin
                                        take_go   = 1'b1;
                                        take_code = {8'd0, part_reg} | {20'd0, b[3:0], 8'd0};
                                        split_go  = 1'b1;
                                    end
                                    default:
                                    begin
                                        take_go   = 1'b1;
                                        take_code = {8'd0, part_reg} | {20'd0, b, 4'd0};
                                        bpos_next = '0;
                                        part_next = '0;
                                    end
                                endcase
                            end
                            default:
                            begin
                                if (bpos_reg >= last_pos)
                                begin
                                    take_go   = 1'b1;
                                    take_code = {8'd0, part_reg}
                                              | ({24'd0, b} << {last_pos, 3'b000});
                                    bpos_next = '0;
                                    part_next = '0;
                                end
                                else
                                begin
                                    part_next = part_reg | ({16'd0, b} << {bpos_reg, 3'b000});
                                    bpos_next = bpos_reg + 2'd1;
                                end
                            end
                        endcase
                    end
                end
            endcase

            // run record or start of a data record
            if (start_go)
            begin
                if (start_type == RT_MISSING || start_type == RT_ZERO)
                begin
                    res_n            = 2'd1;
                    res_a.value      = (start_type == RT_MISSING) ? OUT_OF_RANGE : pred_reg;
                    res_a.repeat_res = start_cnt;
                    phase_next       = PH_HEADER;
                    rem_next         = '0;
                    bpos_next        = '0;
                    part_next        = '0;
                end
                else
                begin
                    phase_next = PH_DATA;
                    rem_next   = start_cnt;
                    bpos_next  = '0;
                    part_next  = '0;
                end
            end

            // first code of this byte
            if (take_go)
            begin
                tk_a             = ddr_take(pred_next, take_code, type_reg);
                res_n            = 2'd1;
                res_a.value      = tk_a.oor ? OUT_OF_RANGE : tk_a.sum;
                res_a.repeat_res = 9'd1;
                if (!tk_a.oor)
                begin
                    pred_next = tk_a.sum;
                end
                rem_next = rem_next - 9'd1;
                if (rem_next == 9'd0)
                begin
                    phase_next = PH_HEADER;
                    bpos_next  = '0;
                    part_next  = '0;
                end

                // high nibble of a 4-bit pair, skipped when the count ran out
                if (pair_go && rem_next != 9'd0)
                begin
                    tk_b             = ddr_take(pred_next, {28'd0, b[7:4]}, RT_D4);
                    res_n            = 2'd2;
                    res_b.value      = tk_b.oor ? OUT_OF_RANGE : tk_b.sum;
                    res_b.repeat_res = 9'd1;
                    if (!tk_b.oor)
                    begin
                        pred_next = tk_b.sum;
                    end
                    rem_next = rem_next - 9'd1;
                    if (rem_next == 9'd0)
                    begin
                        phase_next = PH_HEADER;
                        bpos_next  = '0;
                        part_next  = '0;
                    end
                end

                // middle byte of a 12-bit pair keeps its high nibble
                if (split_go && rem_next != 9'd0)
                begin
                    part_next = {20'd0, b[7:4]};
                    bpos_next = 2'd2;
                end
            end

            // tile end: flags on the last item, then full reset of the parser
            if (byte_ch.tile_end)
            begin
                if (first_reg)
                begin
                    res_n = 2'd0;
                end
                else
                begin
                    if (res_n == 2'd0)
                    begin
                        res_n = 2'd1;
                        res_a = '0;
                    end
                    if (res_n == 2'd2)
                    begin
                        res_b.truncated   = (phase_next != PH_HEADER);
                        res_b.end_of_tile = 1'b1;
                    end
                    else
                    begin
                        res_a.truncated   = (phase_next != PH_HEADER);
                        res_a.end_of_tile = 1'b1;
                    end
                end
                pred_next  = '0;
                type_next  = RT_MISSING;
                phase_next = PH_HEADER;
                rem_next   = '0;
                bpos_next  = '0;
                part_next  = '0;
                first_next = 1'b1;
            end
            else
            begin
                first_next = 1'b0;
            end

            if (res_n == 2'd2)
            begin
                res_b.last_of_item = 1'b1;
            end
            else if (res_n == 2'd1)
            begin
                res_a.last_of_item = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg  <= '0;
            phase_reg <= PH_HEADER;
            type_reg  <= RT_MISSING;
            rem_reg   <= '0;
            bpos_reg  <= '0;
            part_reg  <= '0;
            first_reg <= 1'b1;
            cnt_reg   <= '0;
        end
        else
        begin
            pred_reg  <= pred_next;
            phase_reg <= phase_next;
            type_reg  <= type_next;
            rem_reg   <= rem_next;
            bpos_reg  <= bpos_next;
            part_reg  <= part_next;
            first_reg <= first_next;
            // a byte is only taken when the buffer is empty after this cycle's pop
            if (byte_acc)
            begin
                cnt_reg <= res_n;
            end
            else if (out_pop)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // buffer payload
    always_ff @(posedge clk)
    begin
        if (byte_acc)
        begin
            q0_reg <= res_a;
            q1_reg <= res_b;
        end
        else if (out_pop)
        begin
            q0_reg <= q1_reg;
        end
    end

    assign result_ch.valid        = (cnt_reg != 2'd0);
    assign result_ch.value        = q0_reg.value;
    assign result_ch.repeat_res   = q0_reg.repeat_res;
    assign result_ch.truncated    = q0_reg.truncated;
    assign result_ch.end_of_tile  = q0_reg.end_of_tile;
    assign result_ch.last_of_item = q0_reg.last_of_item;

    // a byte that caused items has them on the output next cycle
    `DDR_ASSERT_NEXT(a_item_follows, clk, rst_n, byte_acc && res_n != 2'd0, result_ch.valid)
    // the tile's closing item is always the last item of its byte
    `DDR_ASSERT_SAME(a_eot_last, clk, rst_n, result_ch.valid && result_ch.end_of_tile, result_ch.last_of_item)
    // a zero repeat only appears on a tile-end status item
    `DDR_ASSERT_SAME(a_zero_rep_eot, clk, rst_n, result_ch.valid && result_ch.repeat_res == 9'd0, result_ch.end_of_tile)
    // predictor and parser restart after the tile's final byte
    `DDR_ASSERT_NEXT(a_tile_reset, clk, rst_n, byte_acc && byte_ch.tile_end, pred_reg == 32'd0 && phase_reg == PH_HEADER && first_reg)

endmodule

`default_nettype wire
